### rtl/clr_pkg.sv
// Shared types and constants for the clipped line rasterizer.
`default_nettype none
package clr_pkg;

    localparam int CoordW  = 12;
    localparam int ErrW    = 14;
    localparam int ColorW  = 16;
    localparam int AddrW   = 17;
    localparam int ClipXW  = 9;
    localparam int ClipYW  = 8;
    localparam int ApbAw   = 4;
    localparam int ApbDw   = 32;

    localparam int ScreenWidthDef  = 320;
    localparam int ScreenHeightDef = 240;

    typedef enum logic [1:0] {
        REG_CLIP_LEFT   = 2'd0,
        REG_CLIP_TOP    = 2'd1,
        REG_CLIP_WIDTH  = 2'd2,
        REG_CLIP_HEIGHT = 2'd3
    } t_reg_idx;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_STEP = 1'b1
    } t_kind;

    typedef struct packed {
        logic                     kind;
        logic signed [CoordW-1:0] start_x;
        logic signed [CoordW-1:0] start_y;
        logic signed [CoordW-1:0] end_x;
        logic signed [CoordW-1:0] end_y;
        logic [ColorW-1:0]        pen_color;
    } t_cmd;

    typedef struct packed {
        logic signed [CoordW-1:0] pixel_x;
        logic signed [CoordW-1:0] pixel_y;
        logic [AddrW-1:0]         pixel_address;
        logic [ColorW-1:0]        pixel_color;
        logic                     write_enable;
        logic                     last;
    } t_pix;

endpackage
`default_nettype wire

### rtl/clr_stream_if.sv
// Valid/ready stream interface carrying one payload struct.
`default_nettype none
interface clr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/clipped_line_rasterizer_core.sv
// Bresenham line rasterizer with screen and clip-window write masking.
//
//  channel   dir  type    payload
//  i_cmd     in   stream  clr_pkg::t_cmd  (load line / step one pixel)
//  o_pix     out  stream  clr_pkg::t_pix  (pixel, address, color, flags)
//  apb       in   APB     clip_left, clip_top, clip_width, clip_height
//
// One command per cycle; a step's pixel goes to the result entry, or to
// the skid entry if o_pix stalls. The line state registers and one 12x12
// address multiply set the single-cycle path. A two-entry output stage
// (result plus skid) keeps i_cmd.ready registered, low while skid is held.
// Reset is synchronous, active low, and leaves the generator idle.
`default_nettype none
module clipped_line_rasterizer_core #(
    parameter int SCREEN_WIDTH  = clr_pkg::ScreenWidthDef,
    parameter int SCREEN_HEIGHT = clr_pkg::ScreenHeightDef
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    clr_stream_if.sink                      i_cmd,
    clr_stream_if.source                    o_pix,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [clr_pkg::ApbAw-1:0]  paddr,
    input  wire logic [clr_pkg::ApbDw-1:0]  pwdata,
    output logic      [clr_pkg::ApbDw-1:0]  prdata,
    output logic                            pready
);

    localparam int CW = clr_pkg::CoordW;
    localparam int EW = clr_pkg::ErrW;
    localparam int XW = clr_pkg::ClipXW;
    localparam int YW = clr_pkg::ClipYW;
    localparam int AW = clr_pkg::AddrW;
    localparam int WideW = 16;

    localparam logic [CW-1:0] ScrW = CW'(SCREEN_WIDTH);
    localparam logic [CW-1:0] ScrH = CW'(SCREEN_HEIGHT);
    localparam logic [XW-1:0] ClipWRst =
        (SCREEN_WIDTH > (1 << XW) - 1) ? XW'((1 << XW) - 1) : XW'(SCREEN_WIDTH);
    localparam logic [YW-1:0] ClipHRst =
        (SCREEN_HEIGHT > (1 << YW) - 1) ? YW'((1 << YW) - 1) : YW'(SCREEN_HEIGHT);

    logic [XW-1:0] r_clip_left, r_clip_width;
    logic [YW-1:0] r_clip_top, r_clip_height;

    logic signed [CW-1:0] r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic        [CW-1:0] r_dx, r_dy;
    logic                 r_sx_neg, r_sy_neg;
    logic signed [EW-1:0] r_err;
    logic [clr_pkg::ColorW-1:0] r_color;
    logic                 r_active;

    clr_pkg::t_pix r_out, r_skid;
    logic          r_out_valid, r_skid_valid;

    logic w_cfg_wr;
    logic w_in_acc, w_is_load, w_push, w_out_fire, w_out_free;

    logic signed [CW:0]    w_ldx, w_ldy;
    logic        [CW-1:0]  w_ldx_abs, w_ldy_abs;

    logic        w_on_scr, w_in_clip, w_we, w_last;
    logic [XW:0] w_clip_xe;
    logic [YW:0] w_clip_ye;
    logic [2*CW-1:0] w_prod;
    logic [AW-1:0]   w_addr;
    clr_pkg::t_pix   w_res;

    logic signed [WideW-1:0] w_e2, w_err_ext, w_err_nx, w_ndy;
    logic                    w_step_x, w_step_y;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (clr_pkg::t_reg_idx'(paddr[3:2]))
            clr_pkg::REG_CLIP_LEFT:   prdata = clr_pkg::ApbDw'(r_clip_left);
            clr_pkg::REG_CLIP_TOP:    prdata = clr_pkg::ApbDw'(r_clip_top);
            clr_pkg::REG_CLIP_WIDTH:  prdata = clr_pkg::ApbDw'(r_clip_width);
            clr_pkg::REG_CLIP_HEIGHT: prdata = clr_pkg::ApbDw'(r_clip_height);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_left   <= '0;
            r_clip_top    <= '0;
            r_clip_width  <= ClipWRst;
            r_clip_height <= ClipHRst;
        end else if (w_cfg_wr) begin
            unique case (clr_pkg::t_reg_idx'(paddr[3:2]))
                clr_pkg::REG_CLIP_LEFT:   r_clip_left   <= pwdata[XW-1:0];
                clr_pkg::REG_CLIP_TOP:    r_clip_top    <= pwdata[YW-1:0];
                clr_pkg::REG_CLIP_WIDTH:  r_clip_width  <= pwdata[XW-1:0];
                clr_pkg::REG_CLIP_HEIGHT: r_clip_height <= pwdata[YW-1:0];
                default: ;
            endcase
        end
    end

    // handshakes
    assign i_cmd.ready = !r_skid_valid;
    assign w_in_acc    = i_cmd.valid && !r_skid_valid;
    assign w_is_load   = (i_cmd.data.kind == clr_pkg::KIND_LOAD);
    assign w_push      = w_in_acc && !w_is_load && r_active;
    assign w_out_fire  = r_out_valid && o_pix.ready;
    assign w_out_free  = !r_out_valid || o_pix.ready;

    // line setup
    always_comb begin
        w_ldx     = (CW+1)'(i_cmd.data.end_x) - (CW+1)'(i_cmd.data.start_x);
        w_ldy     = (CW+1)'(i_cmd.data.end_y) - (CW+1)'(i_cmd.data.start_y);
        w_ldx_abs = w_ldx[CW] ? CW'(-w_ldx) : w_ldx[CW-1:0];
        w_ldy_abs = w_ldy[CW] ? CW'(-w_ldy) : w_ldy[CW-1:0];
    end

    // pixel emit
    always_comb begin
        w_clip_xe = (XW+1)'(r_clip_left) + (XW+1)'(r_clip_width);
        w_clip_ye = (YW+1)'(r_clip_top) + (YW+1)'(r_clip_height);
        w_on_scr  = !r_cur_x[CW-1] && (r_cur_x < ScrW) &&
                    !r_cur_y[CW-1] && (r_cur_y < ScrH);
        w_in_clip = !r_cur_x[CW-1] && !r_cur_y[CW-1] &&
                    (r_cur_x >= CW'(r_clip_left)) && (r_cur_x < CW'(w_clip_xe)) &&
                    (r_cur_y >= CW'(r_clip_top))  && (r_cur_y < CW'(w_clip_ye));
        w_we      = w_on_scr && w_in_clip;
        w_last    = (r_cur_x == r_tgt_x) && (r_cur_y == r_tgt_y);
        w_prod    = r_cur_y * ScrW;
        w_addr    = w_we ? AW'(w_prod + (2*CW)'(r_cur_x)) : '0;

        w_res.pixel_x       = r_cur_x;
        w_res.pixel_y       = r_cur_y;
        w_res.pixel_address = w_addr;
        w_res.pixel_color   = r_color;
        w_res.write_enable  = w_we;
        w_res.last          = w_last;
    end

    // error term advance
    always_comb begin
        w_err_ext = WideW'(r_err);
        w_e2      = w_err_ext <<< 1;
        w_ndy     = -$signed(WideW'(r_dy));
        w_step_x  = (w_e2 >= w_ndy);
        w_step_y  = (w_e2 <= $signed(WideW'(r_dx)));
        w_err_nx  = w_err_ext - (w_step_x ? $signed(WideW'(r_dy)) : '0)
                              + (w_step_y ? $signed(WideW'(r_dx)) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_tgt_x  <= '0;
            r_tgt_y  <= '0;
            r_dx     <= '0;
            r_dy     <= '0;
            r_sx_neg <= 1'b0;
            r_sy_neg <= 1'b0;
            r_err    <= '0;
            r_color  <= '0;
            r_active <= 1'b0;
        end else if (w_in_acc && w_is_load) begin
            r_cur_x  <= i_cmd.data.start_x;
            r_cur_y  <= i_cmd.data.start_y;
            r_tgt_x  <= i_cmd.data.end_x;
            r_tgt_y  <= i_cmd.data.end_y;
            r_dx     <= w_ldx_abs;
            r_dy     <= w_ldy_abs;
            r_sx_neg <= !(i_cmd.data.start_x < i_cmd.data.end_x);
            r_sy_neg <= !(i_cmd.data.start_y < i_cmd.data.end_y);
            r_err    <= EW'(EW'(w_ldx_abs) - EW'(w_ldy_abs));
            r_color  <= i_cmd.data.pen_color;
            r_active <= 1'b1;
        end else if (w_push) begin
            if (w_last) begin
                r_active <= 1'b0;
            end else begin
                if (w_step_x) begin
                    r_cur_x <= r_sx_neg ? r_cur_x - CW'(1) : r_cur_x + CW'(1);
                end
                if (w_step_y) begin
                    r_cur_y <= r_sy_neg ? r_cur_y - CW'(1) : r_cur_y + CW'(1);
                end
                r_err <= w_err_nx[EW-1:0];
            end
        end
    end

    // output register and skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_free) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (w_out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_free) begin
                r_out <= r_skid;
            end
        end else if (w_push) begin
            if (w_out_free) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_pix.valid = r_out_valid;
    assign o_pix.data  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a pending result");

    a_last_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_last) |=> !r_active)
        else $error("generator still active after last pixel");

    a_load_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_is_load) |=> r_active)
        else $error("load transaction did not arm the generator");

    a_masked_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.write_enable) |-> (r_out.pixel_address == '0))
        else $error("nonzero address on a masked pixel");

endmodule
`default_nettype wire
